FILE: hdl/slc_pkg.sv
// Shared types, sizes and codes for the set-associative LRU cache tag core.
// Depends on nothing; every other file imports it.
package slc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int STAMP_WIDTH  = 32;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 64;
  localparam int COUNT_W = 32;
  localparam int SET_COUNT = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W   = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
  } slc_req_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               extra_hit;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
    logic [COUNT_W-1:0] eviction_total;
  } slc_rsp_t;

  typedef struct packed {
    logic                                  full;
    logic [MAX_WAYS-1:0]                   valid;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]  stamp;
    logic [MAX_WAYS-1:0][TAG_W-1:0]        tag;
  } slc_row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free;
    logic [WAY_W-1:0] free_way;
    logic             free_last;
    logic [WAY_W-1:0] victim;
  } slc_look_t;

  typedef struct packed {
    logic fire;
    logic hit_first;
    logic miss;
    logic evict;
    logic modify;
  } slc_upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } slc_state_t;

endpackage

FILE: hdl/slc_row_ram.sv
// Set row memory: one row per set holding tags, stamps, valid bits and full flag.
// Single write port, single registered read port. Uses slc_pkg.
module slc_row_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [slc_pkg::SET_W-1:0] waddr,
  input  slc_pkg::slc_row_t        wdata,
  input  logic                     re,
  input  logic [slc_pkg::SET_W-1:0] raddr,
  output slc_pkg::slc_row_t        rdata
);
  import slc_pkg::*;

  slc_row_t mem [SET_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/slc_lookup.sv
// Way compare for one set row: hit way, first free way and LRU victim.
// Purely combinational; uses slc_pkg.
module slc_lookup (
  input  slc_pkg::slc_row_t         row,
  input  logic [slc_pkg::TAG_W-1:0] tag,
  input  logic [slc_pkg::NW_W-1:0]  nw,
  output slc_pkg::slc_look_t        look
);
  import slc_pkg::*;

  always_comb begin
    logic [STAMP_WIDTH-1:0] best;
    logic                   en;
    look = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      en = NW_W'(w) < nw;
      if (en && row.valid[w] && (row.tag[w] == tag)) begin
        look.hit     = 1'b1;
        look.hit_way = WAY_W'(w);
      end
      if (en && !row.valid[w]) begin
        look.free     = 1'b1;
        look.free_way = WAY_W'(w);
      end
    end
    look.free_last = (NW_W'(look.free_way) + NW_W'(1)) == nw;
    best = row.stamp[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      en = NW_W'(w) < nw;
      if (en && (row.stamp[w] < best)) begin
        best        = row.stamp[w];
        look.victim = WAY_W'(w);
      end
    end
  end

endmodule

FILE: hdl/slc_stats.sv
// Saturating hit, miss and eviction totals plus the wrapping stamp sequence.
// Advanced once per finished item; uses slc_pkg.
module slc_stats (
  input  logic                           clk,
  input  logic                           rst,
  input  slc_pkg::slc_upd_t              upd,
  output logic [slc_pkg::COUNT_W-1:0]    hit_count,
  output logic [slc_pkg::COUNT_W-1:0]    miss_count,
  output logic [slc_pkg::COUNT_W-1:0]    evict_count,
  output logic [slc_pkg::STAMP_WIDTH-1:0] seq
);
  import slc_pkg::*;

  logic [COUNT_W:0]   hit_sum;
  logic [COUNT_W:0]   miss_sum;
  logic [COUNT_W:0]   evict_sum;
  logic [1:0]         hit_inc;

  assign hit_inc   = {1'b0, upd.hit_first} + {1'b0, upd.modify};
  assign hit_sum   = {1'b0, hit_count} + (COUNT_W + 1)'(hit_inc);
  assign miss_sum  = {1'b0, miss_count} + (COUNT_W + 1)'(upd.miss);
  assign evict_sum = {1'b0, evict_count} + (COUNT_W + 1)'(upd.evict);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count   <= '0;
      miss_count  <= '0;
      evict_count <= '0;
      seq         <= '0;
    end else if (upd.fire) begin
      hit_count   <= hit_sum[COUNT_W] ? '1 : hit_sum[COUNT_W-1:0];
      miss_count  <= miss_sum[COUNT_W] ? '1 : miss_sum[COUNT_W-1:0];
      evict_count <= evict_sum[COUNT_W] ? '1 : evict_sum[COUNT_W-1:0];
      seq         <= seq + STAMP_WIDTH'(1);
    end
  end

endmodule

FILE: hdl/set_assoc_lru_cache_tags_core.sv
// Top level of the set-associative LRU cache tag core.
// Uses slc_pkg, slc_row_ram, slc_lookup and slc_stats.
//
// Usage:
//   req carries one access (func, addr) on a valid/ready channel; rsp returns
//   one item per access with the outcome, the modify flag and the running
//   saturating hit, miss and eviction totals after that access.
//   cfg_we/cfg_index/cfg_data write set_bits, block_bits and ways; write them
//   only while no access is outstanding.
// Timing:
//   The row of the addressed set is read at the accepting edge, compared in
//   the next cycle and written back once the output register is free, when
//   the result item is loaded into it. The core takes no new access until
//   that write back, as each access is a read-modify-write of the single
//   row memory.
// Reset:
//   rst clears the per-set row valid flags (no sweep), the totals, the stamp
//   sequence and the output; registers return to 4, 4 and 1.
// Stall:
//   While rsp waits, one more access is accepted and looked up; its write
//   back and result hold until the waiting item is taken.
module set_assoc_lru_cache_tags_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  slc_pkg::slc_req_t                  req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output slc_pkg::slc_rsp_t                  rsp,
  input  logic                               cfg_we,
  input  logic [slc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import slc_pkg::*;

  slc_state_t state, state_next;

  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways;

  logic [SB_W-1:0]   sb;
  logic [NW_W-1:0]   nw;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;

  logic [SET_W-1:0]  cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic              cur_mod;
  logic              row_live;
  logic [SET_COUNT-1:0] row_init;

  slc_row_t  rd_row;
  slc_row_t  row_eff;
  slc_row_t  row_new;
  slc_look_t look;
  slc_look_t look_r;

  logic              accept;
  logic              fire;
  logic              mem_re;
  logic [WAY_W-1:0]  way_sel;
  logic [1:0]        kind;
  slc_upd_t          upd;

  logic [1:0]              outcome_r;
  logic                    extra_r;
  logic [COUNT_W-1:0]      hit_count;
  logic [COUNT_W-1:0]      miss_count;
  logic [COUNT_W-1:0]      evict_count;
  logic [STAMP_WIDTH-1:0]  seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd4;
      block_bits <= 5'd4;
      ways       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:   set_bits   <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits <= cfg_data;
        REG_WAYS:       ways       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sb = (int'(set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits);
    if (ways == 4'd0) begin
      nw = NW_W'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways);
    end
    shifted = req.addr >> block_bits;
    set_in  = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
    tag_in  = shifted >> sb;
  end

  assign accept = req_valid && req_ready;
  assign fire   = (state == ST_UPDATE) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    mem_re     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        mem_re    = req_valid;
        if (req_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_set  <= set_in;
      cur_tag  <= tag_in;
      cur_mod  <= req.func == FUNC_MODIFY;
      row_live <= row_init[set_in];
    end
    if (state == ST_LOOK) begin
      look_r <= look;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (fire) begin
      row_init[cur_set] <= 1'b1;
    end
  end

  slc_row_ram u_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (cur_set),
    .wdata (row_new),
    .re    (mem_re),
    .raddr (set_in),
    .rdata (rd_row)
  );

  always_comb begin
    row_eff = rd_row;
    if (!row_live) begin
      row_eff.valid = '0;
      row_eff.full  = 1'b0;
    end
  end

  slc_lookup u_lookup (
    .row  (row_eff),
    .tag  (cur_tag),
    .nw   (nw),
    .look (look)
  );

  always_comb begin
    row_new = row_eff;
    if (look_r.hit) begin
      kind    = OUT_HIT;
      way_sel = look_r.hit_way;
    end else if (!row_eff.full && look_r.free) begin
      kind    = OUT_MISS;
      way_sel = look_r.free_way;
      if (look_r.free_last) begin
        row_new.full = 1'b1;
      end
    end else begin
      kind    = OUT_EVICT;
      way_sel = look_r.victim;
    end
    row_new.valid[way_sel] = 1'b1;
    row_new.tag[way_sel]   = cur_tag;
    row_new.stamp[way_sel] = seq;
  end

  assign upd.fire      = fire;
  assign upd.hit_first = kind == OUT_HIT;
  assign upd.miss      = kind != OUT_HIT;
  assign upd.evict     = kind == OUT_EVICT;
  assign upd.modify    = cur_mod;

  slc_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .upd         (upd),
    .hit_count   (hit_count),
    .miss_count  (miss_count),
    .evict_count (evict_count),
    .seq         (seq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      outcome_r <= kind;
      extra_r   <= cur_mod;
    end
  end

  assign rsp.outcome        = outcome_r;
  assign rsp.extra_hit      = extra_r;
  assign rsp.hit_total      = hit_count;
  assign rsp.miss_total     = miss_count;
  assign rsp.eviction_total = evict_count;

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOK)
    else $error("accepted item did not enter lookup");

  a_write_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("row write back without a result item");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> hit_count >= $past(hit_count))
    else $error("hit total went down");

  a_modify_counts_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.extra_hit |-> rsp.hit_total != '0)
    else $error("modify item reported with zero hit total");

endmodule

FILE: test/slc_access_checker.sv
`timescale 1ns / 1ps
// Checker for set_assoc_lru_cache_tags_core: watches the config, request and response ports,
// predicts every result item from its own tag/valid/stamp copy and compares field by field.
// Depends on slc_pkg.
module slc_access_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  slc_pkg::slc_req_t               req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  slc_pkg::slc_rsp_t               rsp,
  input  logic                            cfg_we,
  input  logic [slc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import slc_pkg::*;

  localparam int NUM_LINES = SET_COUNT * MAX_WAYS;

  logic [TAG_W-1:0]       tag_mem   [NUM_LINES];
  logic                   valid_mem [NUM_LINES];
  logic [STAMP_WIDTH-1:0] stamp_mem [NUM_LINES];
  logic                   full_mem  [SET_COUNT];
  logic [STAMP_WIDTH-1:0] seq_num;
  logic [COUNT_W-1:0]     hits, misses, evictions;
  logic [2:0]             cfg_set_bits;
  logic [4:0]             cfg_block_bits;
  logic [3:0]             cfg_ways;

  slc_rsp_t pending_results[$];
  slc_rsp_t want;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [1:0] touch_line(int unsigned set, logic [TAG_W-1:0] tag,
                                            int unsigned nw);
    int unsigned base, free_way, victim;
    logic [STAMP_WIDTH-1:0] oldest;
    base = set * MAX_WAYS;
    free_way = nw;
    for (int unsigned w = 0; w < nw; w++) begin
      if (valid_mem[base+w] && tag_mem[base+w] == tag) begin
        stamp_mem[base+w] = seq_num;
        hits = sat_inc(hits);
        return OUT_HIT;
      end
      if (!valid_mem[base+w] && free_way == nw) free_way = w;
    end
    misses = sat_inc(misses);
    if (!full_mem[set] && free_way < nw) begin
      valid_mem[base+free_way] = 1'b1;
      tag_mem[base+free_way] = tag;
      stamp_mem[base+free_way] = seq_num;
      if (free_way == nw - 1) full_mem[set] = 1'b1;
      return OUT_MISS;
    end
    victim = 0;
    oldest = stamp_mem[base];
    for (int unsigned w = 1; w < nw; w++) begin
      if (stamp_mem[base+w] < oldest) begin
        oldest = stamp_mem[base+w];
        victim = w;
      end
    end
    tag_mem[base+victim] = tag;
    valid_mem[base+victim] = 1'b1;
    stamp_mem[base+victim] = seq_num;
    evictions = sat_inc(evictions);
    return OUT_EVICT;
  endfunction

  function automatic slc_rsp_t predict_access(slc_req_t item);
    int unsigned sb, nw, set;
    logic [ADDR_W-1:0] shifted;
    logic [TAG_W-1:0] tag;
    slc_rsp_t r;
    sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
    nw = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways);
    shifted = item.addr >> cfg_block_bits;
    set = 32'(shifted & ((64'd1 << sb) - 64'd1));
    tag = shifted >> sb;
    r.outcome = touch_line(set, tag, nw);
    r.extra_hit = 1'b0;
    if (item.func == FUNC_MODIFY) begin
      void'(touch_line(set, tag, nw));
      r.extra_hit = 1'b1;
    end
    seq_num = seq_num + 1'b1;
    r.hit_total = hits;
    r.miss_total = misses;
    r.eviction_total = evictions;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_val, longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        tag_mem[i] = '0;
        valid_mem[i] = 1'b0;
        stamp_mem[i] = '0;
      end
      for (int i = 0; i < SET_COUNT; i++) full_mem[i] = 1'b0;
      seq_num = '0;
      hits = '0;
      misses = '0;
      evictions = '0;
      cfg_set_bits = 3'd4;
      cfg_block_bits = 5'd4;
      cfg_ways = 4'd1;
      pending_results.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SET_BITS: cfg_set_bits = cfg_data[2:0];
          REG_BLOCK_BITS: cfg_block_bits = cfg_data[4:0];
          REG_WAYS: cfg_ways = cfg_data[3:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          $error("result item with no access outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("outcome", want.outcome, rsp.outcome);
          check_field("extra_hit", want.extra_hit, rsp.extra_hit);
          check_field("hit_total", want.hit_total, rsp.hit_total);
          check_field("miss_total", want.miss_total, rsp.miss_total);
          check_field("eviction_total", want.eviction_total, rsp.eviction_total);
        end
      end
      if (req_valid && req_ready) pending_results.push_back(predict_access(req));
      outstanding <= pending_results.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Top of the cache tag core testbench: clock, reset, register phases, access stimulus,
// response back-pressure, watchdog and verdict. Uses slc_pkg and slc_access_checker.
module tb;
  import slc_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  slc_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  slc_rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_due = 1'b0;

  int phase_sb[NUM_PHASES] = '{7, 6, 3, 0, 2, 4, 1, 5};
  int phase_bb[NUM_PHASES] = '{31, 0, 16, 4, 6, 4, 20, 2};
  int phase_ways[NUM_PHASES] = '{15, 8, 8, 5, 3, 2, 1, 0};

  set_assoc_lru_cache_tags_core uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  slc_access_checker chk (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic send_access(logic [1:0] f, logic [ADDR_W-1:0] a);
    slc_req_t item;
    int gap;
    item.func = f;
    item.addr = a;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic write_settings(int sb, int bb, int nw);
    cfg_we <= 1'b1;
    cfg_index <= REG_SET_BITS;
    cfg_data <= sb[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_BLOCK_BITS;
    cfg_data <= bb[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_WAYS;
    cfg_data <= nw[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // set bits 7 (clamped to 6), block bits 31, ways 15 (clamped to eight): set = addr[36:31], tag = addr[63:37]
  task automatic run_directed();
    send_access(FUNC_LOAD, 64'd0);
    send_access(FUNC_STORE, '1);
    send_access(FUNC_MODIFY, 64'd0);
    send_access(FUNC_SPARE, '1);
    send_access(FUNC_LOAD, 64'h0000_001F_8000_0000);
    for (int t = 1; t <= 9; t++) send_access(FUNC_STORE, 64'(t) << 37);
    send_access(FUNC_LOAD, 64'd0);
    send_access(FUNC_MODIFY, 64'h0000_0000_7FFF_FFFF);
    send_access(FUNC_SPARE, 64'd9 << 37);
    send_access(FUNC_MODIFY, 64'h8000_0000_0000_0000);
    send_access(FUNC_LOAD, 64'h0000_0001_0000_0000);
    send_access(FUNC_STORE, 64'h5555_5555_5555_5555);
    send_access(FUNC_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr(int sb, int bb, int nw,
                                                  logic [63:0] tag_base,
                                                  logic [63:0] set_base);
    logic [63:0] tag, set, off;
    if ($urandom_range(99) < 8) return {$urandom, $urandom};
    tag = tag_base + 64'($urandom_range(nw + 1));
    set = (set_base + 64'($urandom_range(2))) & ((64'd1 << sb) - 64'd1);
    off = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
    return (tag << (sb + bb)) | (set << bb) | off;
  endfunction

  task automatic run_random(int sb, int bb, int nw);
    int sb_eff, nw_eff;
    logic [63:0] tag_base, set_base;
    sb_eff = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    nw_eff = (nw == 0) ? 1 : ((nw > MAX_WAYS) ? MAX_WAYS : nw);
    tag_base = {$urandom, $urandom};
    set_base = 64'($urandom);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      calm = (i < 30);
      send_access(2'($urandom_range(3)), pick_addr(sb_eff, bb, nw_eff, tag_base, set_base));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) drain();
      write_settings(phase_sb[p], phase_bb[p], phase_ways[p]);
      if (p == 0) run_directed();
      if (p == 1) hold_due = 1'b1;
      run_random(phase_sb[p], phase_bb[p], phase_ways[p]);
    end
    drain();
    if (mismatches == 0) begin
      $display("set_assoc_lru_cache_tags_core regression: pass");
    end else begin
      $display("set_assoc_lru_cache_tags_core regression: fail");
    end
    $finish;
  end

  initial begin
    int run, gap;
    bit held;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_due && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      run = $urandom_range(20, 1);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("set_assoc_lru_cache_tags_core regression: fail");
        $finish;
      end
    end
  end

endmodule
